### hdl/mlpts_pkg.sv
package mlpts_pkg;

  localparam int WW = 32;
  localparam int SIG_DEPTH = 256;
  localparam int SIG_AW = $clog2(SIG_DEPTH);
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] ADDR_LR = 2'd0;
  localparam logic [15:0] LR_RESET = 16'd6554;

  localparam logic signed [WW-1:0] W1_INIT0 = WW'(6554);
  localparam logic signed [WW-1:0] W1_INIT1 = -WW'(13107);
  localparam logic signed [WW-1:0] W1_INIT2 = WW'(19661);
  localparam logic signed [WW-1:0] W1_INIT3 = WW'(26214);
  localparam logic signed [WW-1:0] W2_INIT0 = WW'(32768);
  localparam logic signed [WW-1:0] W2_INIT1 = -WW'(39322);

  typedef enum logic [4:0] {
    OP_NONE, OP_H00, OP_H10, OP_H01, OP_H11, OP_O0, OP_O1, OP_LE, OP_EH0, OP_EH1,
    OP_UW0, OP_UW1, OP_LH0, OP_LH1, OP_U00, OP_U10, OP_U01, OP_U11
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_H00, ST_H10, ST_H01, ST_H11, ST_O0, ST_O1, ST_ZF, ST_SIG, ST_LE,
    ST_EH0, ST_EH1, ST_UW0, ST_UW1, ST_LH0, ST_LH1, ST_U00, ST_U10, ST_U01, ST_U11,
    ST_LAST, ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic sig;
    logic out_load;
  } cmd_t;

  typedef logic [12:0] rom_t [SIG_DEPTH];

  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_t sig_build();
    rom_t r;
    longint zq;
    longint unsigned y;
    longint unsigned u;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned d;
    longint unsigned s;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      zq = ((longint'(k) << 20) >> SIG_AW) - (longint'(1) << 19);
      y = (zq < 0) ? longint'(-zq) : longint'(zq);
      u = y << 4;
      term = 64'd1 << 24;
      sum = 64'd1 << 24;
      for (int n = 1; n <= 12; n++) begin
        term = udiv(term * u, longint'(n) << 24);
        sum = sum + term;
      end
      for (int n = 0; n < 4; n++) begin
        sum = (sum * sum) >> 24;
      end
      d = (64'd1 << 24) + sum;
      s = udiv((64'd1 << 36) + (d >> 1), d);
      r[k] = (zq < 0) ? 13'(s) : 13'(64'd4096 - s);
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = sig_build();

  function automatic logic signed [WW-1:0] sat_p(input logic signed [2*WW-1:0] v);
    logic signed [2*WW-1:0] hi;
    logic signed [2*WW-1:0] lo;
    hi = (2*WW)'({1'b0, {(WW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return WW'(hi);
    if (v < lo) return WW'(lo);
    return v[WW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] sat_s(input logic signed [WW+1:0] v);
    logic signed [WW+1:0] hi;
    logic signed [WW+1:0] lo;
    hi = (WW+2)'({1'b0, {(WW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return WW'(hi);
    if (v < lo) return WW'(lo);
    return v[WW-1:0];
  endfunction

endpackage

### hdl/mlpts_if.sv
interface mlpts_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature_a;
  logic signed [15:0] feature_b;
  logic        [12:0] target;
  modport source (output valid, feature_a, feature_b, target, input ready);
  modport sink (input valid, feature_a, feature_b, target, output ready);
endinterface

interface mlpts_result_if;
  logic               valid;
  logic               ready;
  logic        [12:0] prediction;
  logic signed [13:0] residual;
  modport source (output valid, prediction, residual, input ready);
  modport sink (input valid, prediction, residual, output ready);
endinterface

### hdl/mlpts_ctrl.sv
module mlpts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mlpts_pkg::cmd_t cmd_o
);
  import mlpts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_H00;
        end
      end
      ST_H00: begin cmd_o.op = OP_H00; state_d = ST_H10; end
      ST_H10: begin cmd_o.op = OP_H10; state_d = ST_H01; end
      ST_H01: begin cmd_o.op = OP_H01; state_d = ST_H11; end
      ST_H11: begin cmd_o.op = OP_H11; state_d = ST_O0; end
      ST_O0:  begin cmd_o.op = OP_O0;  state_d = ST_O1; end
      ST_O1:  begin cmd_o.op = OP_O1;  state_d = ST_ZF; end
      ST_ZF:  state_d = ST_SIG;
      ST_SIG: begin cmd_o.sig = 1'b1; state_d = ST_LE; end
      ST_LE:  begin cmd_o.op = OP_LE;  state_d = ST_EH0; end
      ST_EH0: begin cmd_o.op = OP_EH0; state_d = ST_EH1; end
      ST_EH1: begin cmd_o.op = OP_EH1; state_d = ST_UW0; end
      ST_UW0: begin cmd_o.op = OP_UW0; state_d = ST_UW1; end
      ST_UW1: begin cmd_o.op = OP_UW1; state_d = ST_LH0; end
      ST_LH0: begin cmd_o.op = OP_LH0; state_d = ST_LH1; end
      ST_LH1: begin cmd_o.op = OP_LH1; state_d = ST_U00; end
      ST_U00: begin cmd_o.op = OP_U00; state_d = ST_U10; end
      ST_U10: begin cmd_o.op = OP_U10; state_d = ST_U01; end
      ST_U01: begin cmd_o.op = OP_U01; state_d = ST_U11; end
      ST_U11: begin cmd_o.op = OP_U11; state_d = ST_LAST; end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

endmodule

### hdl/mlpts_dp.sv
module mlpts_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlpts_pkg::cmd_t     cmd_i,
  input  logic [15:0]         lr_i,
  input  logic signed [15:0]  feature_a_i,
  input  logic signed [15:0]  feature_b_i,
  input  logic [12:0]         target_i,
  output logic [12:0]         prediction_o,
  output logic signed [13:0]  residual_o
);
  import mlpts_pkg::*;

  logic signed [WW-1:0]   w1_q [4];
  logic signed [WW-1:0]   b1_q [2];
  logic signed [WW-1:0]   w2_q [2];
  logic signed [WW-1:0]   b2_q;
  logic signed [WW-1:0]   z1_q [2];
  logic signed [WW-1:0]   z2_q, le_q;
  logic signed [WW-1:0]   eh_q [2];
  logic signed [WW-1:0]   lh_q [2];
  logic signed [WW+1:0]   acc_q;
  logic signed [15:0]     x0_q, x1_q;
  logic [12:0]            tgt_q, pred_q;
  logic signed [2*WW-1:0] p_q;
  op_e                    tag_q;
  logic [12:0]            out_pred_q;
  logic signed [13:0]     out_res_q;

  logic signed [WW-1:0]   a1_0, a1_1, e_w, x0_w, x1_w, lr_w, op_a, op_b, m;
  logic signed [13:0]     err;
  logic signed [2*WW-1:0] p_sh;
  logic signed [19:0]     zc;
  logic [19:0]            zoff;

  assign a1_0 = (z1_q[0] > 0) ? z1_q[0] : '0;
  assign a1_1 = (z1_q[1] > 0) ? z1_q[1] : '0;
  assign err  = $signed({1'b0, pred_q}) - $signed({1'b0, tgt_q});
  assign e_w  = WW'(err) <<< 4;
  assign x0_w = WW'(x0_q);
  assign x1_w = WW'(x1_q);
  assign lr_w = WW'({1'b0, lr_i});

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.op)
      OP_H00: begin op_a = x0_w; op_b = w1_q[0]; end
      OP_H10: begin op_a = x1_w; op_b = w1_q[2]; end
      OP_H01: begin op_a = x0_w; op_b = w1_q[1]; end
      OP_H11: begin op_a = x1_w; op_b = w1_q[3]; end
      OP_O0:  begin op_a = a1_0; op_b = w2_q[0]; end
      OP_O1:  begin op_a = a1_1; op_b = w2_q[1]; end
      OP_LE:  begin op_a = lr_w; op_b = e_w; end
      OP_EH0: begin op_a = e_w;  op_b = w2_q[0]; end
      OP_EH1: begin op_a = e_w;  op_b = w2_q[1]; end
      OP_UW0: begin op_a = le_q; op_b = a1_0; end
      OP_UW1: begin op_a = le_q; op_b = a1_1; end
      OP_LH0: begin op_a = lr_w; op_b = eh_q[0]; end
      OP_LH1: begin op_a = lr_w; op_b = eh_q[1]; end
      OP_U00: begin op_a = lh_q[0]; op_b = x0_w; end
      OP_U10: begin op_a = lh_q[0]; op_b = x1_w; end
      OP_U01: begin op_a = lh_q[1]; op_b = x0_w; end
      OP_U11: begin op_a = lh_q[1]; op_b = x1_w; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    case (tag_q) inside
      OP_H00, OP_H10, OP_H01, OP_H11, OP_U00, OP_U10, OP_U01, OP_U11: p_sh = p_q >>> 12;
      default: p_sh = p_q >>> 16;
    endcase
    m = sat_p(p_sh);
  end

  assign zc   = (z2_q < -(WW'(1) <<< 19)) ? -(20'sd1 <<< 19) :
                (z2_q > ((WW'(1) <<< 19) - 1)) ? (20'sd1 <<< 19) - 20'sd1 : z2_q[19:0];
  assign zoff = zc + (20'sd1 <<< 19);

  always_ff @(posedge clk_i) begin
    p_q <= op_a * op_b;
    if (cmd_i.load) begin
      x0_q  <= feature_a_i;
      x1_q  <= feature_b_i;
      tgt_q <= target_i;
    end
    if (cmd_i.sig) begin
      pred_q <= SIG_ROM[zoff[19 -: SIG_AW]];
    end
    if (cmd_i.out_load) begin
      out_pred_q <= pred_q;
      out_res_q  <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= OP_NONE;
      w1_q[0] <= W1_INIT0;
      w1_q[1] <= W1_INIT1;
      w1_q[2] <= W1_INIT2;
      w1_q[3] <= W1_INIT3;
      b1_q[0] <= '0;
      b1_q[1] <= '0;
      w2_q[0] <= W2_INIT0;
      w2_q[1] <= W2_INIT1;
      b2_q    <= '0;
      z1_q[0] <= '0;
      z1_q[1] <= '0;
      z2_q    <= '0;
      le_q    <= '0;
      eh_q[0] <= '0;
      eh_q[1] <= '0;
      lh_q[0] <= '0;
      lh_q[1] <= '0;
      acc_q   <= '0;
    end else begin
      tag_q <= cmd_i.op;
      unique case (tag_q)
        OP_H00: acc_q <= (WW+2)'(m) + (WW+2)'(b1_q[0]);
        OP_H10: z1_q[0] <= sat_s(acc_q + (WW+2)'(m));
        OP_H01: acc_q <= (WW+2)'(m) + (WW+2)'(b1_q[1]);
        OP_H11: z1_q[1] <= sat_s(acc_q + (WW+2)'(m));
        OP_O0:  acc_q <= (WW+2)'(m) + (WW+2)'(b2_q);
        OP_O1:  z2_q <= sat_s(acc_q + (WW+2)'(m));
        OP_LE: begin
          le_q <= m;
          b2_q <= sat_s((WW+2)'(b2_q) - (WW+2)'(m));
        end
        OP_EH0: eh_q[0] <= (z1_q[0] > 0) ? m : '0;
        OP_EH1: eh_q[1] <= (z1_q[1] > 0) ? m : '0;
        OP_UW0: w2_q[0] <= sat_s((WW+2)'(w2_q[0]) - (WW+2)'(m));
        OP_UW1: w2_q[1] <= sat_s((WW+2)'(w2_q[1]) - (WW+2)'(m));
        OP_LH0: begin
          lh_q[0] <= m;
          b1_q[0] <= sat_s((WW+2)'(b1_q[0]) - (WW+2)'(m));
        end
        OP_LH1: begin
          lh_q[1] <= m;
          b1_q[1] <= sat_s((WW+2)'(b1_q[1]) - (WW+2)'(m));
        end
        OP_U00: w1_q[0] <= sat_s((WW+2)'(w1_q[0]) - (WW+2)'(m));
        OP_U10: w1_q[2] <= sat_s((WW+2)'(w1_q[2]) - (WW+2)'(m));
        OP_U01: w1_q[1] <= sat_s((WW+2)'(w1_q[1]) - (WW+2)'(m));
        OP_U11: w1_q[3] <= sat_s((WW+2)'(w1_q[3]) - (WW+2)'(m));
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign prediction_o = out_pred_q;
  assign residual_o   = out_res_q;

endmodule

### hdl/mlp_online_training_step_top.sv
// Online SGD training step for a 2-2-1 network (ReLU hidden, sigmoid out).
// sample_i: one request carries feature_a, feature_b (Q4.12) and target
//   (Q0.12); accepted when valid and ready are both high.
// result_o: one result per request, prediction (Q0.12) taken before the
//   weight update and residual = prediction - target.
// APB port: register 0 at byte address 0 holds the learning rate (Q0.16).
// The single shared 32x32 multiplier makes 17 passes per request
//   (forward, errors, nine weight updates); the controller also steps
//   through the last sum, the sigmoid table read, the last weight write
//   and the output load, and a new request is taken only in its idle
//   state, once the previous request has finished.
// The result sits in an output register; when the receiver stalls, one
//   further request is computed and waits in its last step, and no request
//   after that is taken until the output register frees.
// Reset restores the initial weights, zero biases and a learning rate of
//   6554; no result is pending after reset.
module mlp_online_training_step_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mlpts_sample_if.sink                   sample_i,
  mlpts_result_if.source                 result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlpts_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mlpts_pkg::*;

  logic [15:0] lr_q;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_LR) begin
      lr_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LR) ? {16'd0, lr_q} : 32'd0;

  mlpts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  mlpts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .lr_i         (lr_q),
    .feature_a_i  (sample_i.feature_a),
    .feature_b_i  (sample_i.feature_b),
    .target_i     (sample_i.target),
    .prediction_o (result_o.prediction),
    .residual_o   (result_o.residual)
  );

endmodule
